@@ sv/nfsr_pkg.sv @@
// ----------------------------------------------------------------------------
// nfsr_pkg: shared types and defaults for the NMRU-FIFO set replacement block
// Beat layouts for both channels, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package nfsr_pkg;

	localparam int WAYS_DEF        = 4;
	localparam int BLOCK_BYTES_DEF = 64;
	localparam int TAG_BITS_DEF    = 32;

	localparam int TAG_IN_W = 32;
	localparam int LINE_W   = 64;
	localparam int OFF_W    = 6;

	// access kinds
	localparam logic KIND_TOUCH = 1'b0;
	localparam logic KIND_FILL  = 1'b1;

	typedef struct packed {
		logic                kind;
		logic [TAG_IN_W-1:0] line_tag;
		logic [OFF_W-1:0]    byte_offset;
	} in_beat_t;

	typedef struct packed {
		logic                evicted;
		logic [TAG_IN_W-1:0] evicted_tag;
		logic [LINE_W-1:0]   line_valid_mask;
		logic                tag_missing;
	} out_beat_t;

endpackage

@@ sv/nfsr_in_stage.sv @@
// ----------------------------------------------------------------------------
// nfsr_in_stage: input register
// Captures one access beat; holds it while the set logic cannot take it.
// ----------------------------------------------------------------------------
module nfsr_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_stall,
	input  nfsr_pkg::in_beat_t up_beat,
	input  logic              take,
	output logic              valid_s1,
	output nfsr_pkg::in_beat_t beat_s1
);
	import nfsr_pkg::*;

	assign up_stall = valid_s1 & ~take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!up_stall) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!up_stall && up_valid) begin
			beat_s1 <= up_beat;
		end
	end

endmodule

@@ sv/nfsr_set_core.sv @@
// ----------------------------------------------------------------------------
// nfsr_set_core: set state and its update logic
// Way tags, per-byte valid bits and the most recent tag; computes the result
// of the beat in the input register and commits the new state on take.
// ----------------------------------------------------------------------------
module nfsr_set_core #(
	parameter int WAYS        = nfsr_pkg::WAYS_DEF,
	parameter int BLOCK_BYTES = nfsr_pkg::BLOCK_BYTES_DEF,
	parameter int TAG_BITS    = nfsr_pkg::TAG_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               blocking_fetch,
	input  logic               take,
	input  nfsr_pkg::in_beat_t  beat,
	output nfsr_pkg::out_beat_t result
);
	import nfsr_pkg::*;

	localparam int TW = (TAG_BITS < TAG_IN_W) ? TAG_BITS : TAG_IN_W;
	localparam int BB = BLOCK_BYTES;
	// second oldest way, or the oldest when there is only one
	localparam int W1 = (WAYS > 1) ? 1 : 0;

	logic [TW-1:0] tags_q  [WAYS];
	logic [BB-1:0] valid_q [WAYS];
	logic [TW-1:0] recent_q;

	logic [TW-1:0] tags_d  [WAYS];
	logic [BB-1:0] valid_d [WAYS];
	logic [TW-1:0] recent_d;

	logic [TW-1:0]   tag;
	logic [BB-1:0]   fetch;
	logic            skip_oldest;
	logic [WAYS-1:0] hit;
	logic [WAYS-1:0] sel;
	logic            found;

	assign tag = beat.line_tag[TW-1:0];

	always_comb begin
		for (int i = 0; i < BB; i++) begin
			fetch[i] = blocking_fetch | (OFF_W'(i) >= beat.byte_offset);
		end
	end

	assign skip_oldest = (WAYS > 1) && (recent_q == tags_q[0]);

	// lowest matching way wins
	always_comb begin
		logic seen;
		seen = 1'b0;
		for (int i = 0; i < WAYS; i++) begin
			hit[i] = (tags_q[i] == tag);
			sel[i] = hit[i] & ~seen;
			seen   = seen | hit[i];
		end
	end

	assign found = |hit;

	always_comb begin
		logic [BB-1:0] victim_valid;
		logic [TW-1:0] victim_tag;
		logic [BB-1:0] touched;
		victim_valid = skip_oldest ? valid_q[W1] : valid_q[0];
		victim_tag   = skip_oldest ? tags_q[W1]  : tags_q[0];
		touched      = '0;
		for (int i = 0; i < WAYS; i++) begin
			tags_d[i]  = tags_q[i];
			valid_d[i] = valid_q[i];
		end
		recent_d = recent_q;
		result   = '0;
		if (beat.kind == KIND_FILL) begin
			// shift ways above the victim down one place, new line goes last
			for (int i = 0; i < WAYS - 1; i++) begin
				if (i != 0 || !skip_oldest) begin
					tags_d[i]  = tags_q[i+1];
					valid_d[i] = valid_q[i+1];
				end
			end
			tags_d[WAYS-1]  = tag;
			valid_d[WAYS-1] = fetch;
			recent_d        = tag;
			result.evicted         = |victim_valid;
			result.evicted_tag     = (|victim_valid) ? TAG_IN_W'(victim_tag) : '0;
			result.line_valid_mask = LINE_W'(fetch);
		end else if (found) begin
			for (int i = 0; i < WAYS; i++) begin
				if (sel[i]) begin
					valid_d[i] = valid_q[i] | fetch;
					touched    = touched | valid_d[i];
				end
			end
			recent_d               = tag;
			result.line_valid_mask = LINE_W'(touched);
		end else begin
			result.tag_missing = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WAYS; i++) begin
				tags_q[i]  <= '0;
				valid_q[i] <= '0;
			end
			recent_q <= '0;
		end else if (take) begin
			for (int i = 0; i < WAYS; i++) begin
				tags_q[i]  <= tags_d[i];
				valid_q[i] <= valid_d[i];
			end
			recent_q <= recent_d;
		end
	end

endmodule

@@ sv/nfsr_out_stage.sv @@
// ----------------------------------------------------------------------------
// nfsr_out_stage: result register
// Holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module nfsr_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  nfsr_pkg::out_beat_t result,
	output logic               ready,
	output logic               valid_s2,
	input  logic               down_stall,
	output nfsr_pkg::out_beat_t beat_s2
);
	import nfsr_pkg::*;

	assign ready = ~valid_s2 | ~down_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load) begin
			beat_s2 <= result;
		end
	end

endmodule

@@ sv/nmru_fifo_set_replacement_top.sv @@
// ----------------------------------------------------------------------------
// nmru_fifo_set_replacement_top: NMRU-FIFO replacement for one cache set
// Path from input beat to result beat: input reg, then result reg.
// Throughput: 1 beat per cycle while out_stall does not hold the result; the set state updates on each take.
// Reset (arst_n low): tags, byte valids, recent tag and blocking_fetch clear.
// ----------------------------------------------------------------------------
module nmru_fifo_set_replacement_top #(
	parameter int WAYS        = nfsr_pkg::WAYS_DEF,
	parameter int BLOCK_BYTES = nfsr_pkg::BLOCK_BYTES_DEF,
	parameter int TAG_BITS    = nfsr_pkg::TAG_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// config: single register, write only
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	// access channel
	input  logic               in_valid,
	output logic               in_stall,
	input  nfsr_pkg::in_beat_t  in_beat,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output nfsr_pkg::out_beat_t out_beat
);
	import nfsr_pkg::*;

	// Flow: the input register feeds the set logic; when the result register
	// can load (empty or being drained), the beat is taken, the set state is
	// committed and the result is captured in the same edge. A new access can
	// be accepted while a finished result waits for the consumer.

	logic      blocking_fetch_q;
	logic      valid_s1;
	in_beat_t  beat_s1;
	logic      take;
	logic      out_ready;
	out_beat_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocking_fetch_q <= 1'b0;
		end else if (cfg_we) begin
			blocking_fetch_q <= cfg_wdata;
		end
	end

	assign take = valid_s1 & out_ready;

	nfsr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (in_valid),
		.up_stall (in_stall),
		.up_beat  (in_beat),
		.take     (take),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	// tag compare, victim pick, way shift and byte-valid merge
	nfsr_set_core #(
		.WAYS        (WAYS),
		.BLOCK_BYTES (BLOCK_BYTES),
		.TAG_BITS    (TAG_BITS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.blocking_fetch (blocking_fetch_q),
		.take           (take),
		.beat           (beat_s1),
		.result         (result)
	);

	nfsr_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (valid_s1),
		.result     (result),
		.ready      (out_ready),
		.valid_s2   (out_valid),
		.down_stall (out_stall),
		.beat_s2    (out_beat)
	);

endmodule

@@ tb/tb_nmru_fifo_set_replacement_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nmru_fifo_set_replacement_top: self-checking bench for the NMRU-FIFO set
// Keeps its own copy of the set (tags, byte valids, MRU tag, fetch mode) and
// predicts every result beat. It runs a directed pass over the policy corners,
// then random touch/fill traffic under several idle and stall mixes in both
// fetch modes.
// ----------------------------------------------------------------------------
module tb_nmru_fifo_set_replacement_top;
	import nfsr_pkg::*;

	localparam int WAYS        = WAYS_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DUT_LATENCY = 2;

	// DUT ports; every input has a known value from time zero
	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cfg_we    = 1'b0;
	logic      cfg_wdata = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_stall;
	in_beat_t  in_beat   = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_beat_t out_beat;

	// shadow copy of the set
	logic [TAG_IN_W-1:0] shadow_tag   [WAYS];
	logic [LINE_W-1:0]   shadow_bytes [WAYS];
	logic [TAG_IN_W-1:0] shadow_mru;
	logic                shadow_blocking;

	out_beat_t pending_results [$];

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int error_count   = 0;
	int cycle_count   = 0;

	logic [TAG_IN_W-1:0] tag_pool [8];

	nmru_fifo_set_replacement_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_beat   (in_beat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// run guard: a hung handshake ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver: random stall per the current mix, none while in reset
	always @(posedge clk) begin
		if (!arst_n || stall_pct == 0)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Apply one access to the shadow set and return the expected result beat.
	function automatic out_beat_t set_policy_step(in_beat_t b);
		out_beat_t         r;
		logic [LINE_W-1:0] fetched;
		int                victim;
		int                hit_way;
		r = '0;
		// bytes brought in by this access; the offset is always inside the block
		if (shadow_blocking)
			fetched = '1;
		else
			fetched = {LINE_W{1'b1}} << b.byte_offset;
		if (b.kind == KIND_FILL) begin
			// oldest way goes, unless it holds the MRU tag: then the second oldest
			victim = (WAYS > 1 && shadow_mru == shadow_tag[0]) ? 1 : 0;
			if (shadow_bytes[victim] != '0) begin
				r.evicted     = 1'b1;
				r.evicted_tag = shadow_tag[victim];
			end
			for (int i = victim + 1; i < WAYS; i++) begin
				shadow_tag[i-1]   = shadow_tag[i];
				shadow_bytes[i-1] = shadow_bytes[i];
			end
			shadow_tag[WAYS-1]   = b.line_tag;
			shadow_bytes[WAYS-1] = fetched;
			shadow_mru           = b.line_tag;
			r.line_valid_mask    = fetched;
		end else begin
			// lowest way wins when a tag sits in more than one way
			hit_way = -1;
			for (int i = WAYS - 1; i >= 0; i--)
				if (shadow_tag[i] == b.line_tag)
					hit_way = i;
			if (hit_way < 0) begin
				r.tag_missing = 1'b1;   // nothing changes, MRU included
			end else begin
				shadow_bytes[hit_way] = shadow_bytes[hit_way] | fetched;
				shadow_mru            = b.line_tag;
				r.line_valid_mask     = shadow_bytes[hit_way];
			end
		end
		return r;
	endfunction

	// Checker. Inputs only move at posedge, so the values seen at negedge are
	// the ones the DUT and the bench see at the next rising edge.
	always @(negedge clk) begin
		out_beat_t exp_beat;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result beat: %p", out_beat);
				error_count++;
			end else begin
				exp_beat = pending_results.pop_front();
				if (out_beat.evicted !== exp_beat.evicted) begin
					$error("evicted: expected %0b, got %0b",
						exp_beat.evicted, out_beat.evicted);
					error_count++;
				end
				if (out_beat.evicted_tag !== exp_beat.evicted_tag) begin
					$error("evicted_tag: expected %h, got %h",
						exp_beat.evicted_tag, out_beat.evicted_tag);
					error_count++;
				end
				if (out_beat.line_valid_mask !== exp_beat.line_valid_mask) begin
					$error("line_valid_mask: expected %h, got %h",
						exp_beat.line_valid_mask, out_beat.line_valid_mask);
					error_count++;
				end
				if (out_beat.tag_missing !== exp_beat.tag_missing) begin
					$error("tag_missing: expected %0b, got %0b",
						exp_beat.tag_missing, out_beat.tag_missing);
					error_count++;
				end
			end
		end
	end

	// Send one access beat; called and returning right after a rising edge.
	// The prediction is queued at the edge where the beat is taken.
	task automatic send_access(input logic kind, input logic [TAG_IN_W-1:0] tag,
			input logic [OFF_W-1:0] off);
		in_beat_t b;
		logic     stalled;
		b.kind        = kind;
		b.line_tag    = tag;
		b.byte_offset = off;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_beat  <= b;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		pending_results.push_back(set_policy_step(b));
	endtask

	// Stop sending and wait for every expected beat, plus the pipe depth.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DUT_LATENCY + 2) @(posedge clk);
	endtask

	// Fetch mode changes only with the block idle.
	task automatic set_fetch_mode(input logic mode);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we          <= 1'b0;
		shadow_blocking  = mode;
	endtask

	// Reset contents: tag zero is a real entry, first fill skips way 0.
	task automatic test_reset_entries();
		send_access(KIND_TOUCH, 32'h0000_0000, 6'd0);
		send_access(KIND_TOUCH, 32'hDEAD_BEEF, 6'd10);  // absent tag
		send_access(KIND_FILL,  32'hFFFF_FFFF, 6'd63);  // replaces empty way 1
		send_access(KIND_FILL,  32'h0000_0001, 6'd0);   // evicts valid tag-zero way
	endtask

	// FIFO order, MRU protection, duplicate tags, OR-only touches.
	task automatic test_directed_policy();
		send_access(KIND_TOUCH, 32'hFFFF_FFFF, 6'd0);
		send_access(KIND_FILL,  32'hA5A5_A5A5, 6'd32);
		send_access(KIND_TOUCH, 32'h0000_0001, 6'd40);
		send_access(KIND_FILL,  32'h5A5A_5A5A, 6'd1);
		send_access(KIND_TOUCH, 32'hFFFF_FFFF, 6'd20);  // oldest becomes MRU
		send_access(KIND_FILL,  32'h1234_5678, 6'd63);  // second oldest goes
		send_access(KIND_FILL,  32'h1234_5678, 6'd7);   // same tag in two ways
		send_access(KIND_TOUCH, 32'h1234_5678, 6'd0);   // lowest of the two
		send_access(KIND_TOUCH, 32'h0000_0000, 6'd5);   // gone by now
		send_access(KIND_TOUCH, 32'hA5A5_A5A5, 6'd63);
		send_access(KIND_FILL,  32'h0000_0000, 6'd63);
	endtask

	// Whole-line fetch ignores the offset on fills and touches.
	task automatic test_blocking_fetch();
		set_fetch_mode(1'b1);
		send_access(KIND_FILL,  32'h0F0F_0F0F, 6'd63);
		send_access(KIND_TOUCH, 32'h5A5A_5A5A, 6'd63);
		send_access(KIND_TOUCH, 32'h7777_7777, 6'd0);   // absent tag
		send_access(KIND_FILL,  32'hF0F0_F0F0, 6'd0);
		send_access(KIND_TOUCH, 32'h0000_0000, 6'd33);
		set_fetch_mode(1'b0);
	endtask

	// Random traffic: mostly touches of resident tags and fills from a small
	// pool, so tags recycle and MRU protection kicks in often.
	task automatic test_random_traffic(input int n_items, input logic mode,
			input int idle, input int stall);
		int                  sel;
		int                  osel;
		logic [TAG_IN_W-1:0] tag;
		logic [OFF_W-1:0]    off;
		set_fetch_mode(mode);
		send_idle_pct = idle;
		stall_pct     = stall;
		tag_pool[0]   = 32'h0000_0000;
		tag_pool[1]   = 32'hFFFF_FFFF;
		for (int i = 2; i < 8; i++)
			tag_pool[i] = $urandom;
		for (int i = 0; i < n_items; i++) begin
			osel = $urandom_range(9);
			if (osel == 0)
				off = '0;
			else if (osel == 1)
				off = '1;
			else
				off = OFF_W'($urandom_range(63));
			sel = $urandom_range(99);
			if (sel < 40) begin
				tag = ($urandom_range(9) == 0) ? $urandom : tag_pool[$urandom_range(7)];
				send_access(KIND_FILL, tag, off);
			end else if (sel < 85) begin
				send_access(KIND_TOUCH, shadow_tag[$urandom_range(WAYS-1)], off);
			end else begin
				tag = ($urandom_range(1) == 0) ? $urandom : tag_pool[$urandom_range(7)];
				send_access(KIND_TOUCH, tag, off);
			end
		end
		send_idle_pct = 0;
		stall_pct     = 0;
	endtask

	initial begin
		for (int i = 0; i < WAYS; i++) begin
			shadow_tag[i]   = '0;
			shadow_bytes[i] = '0;
		end
		shadow_mru      = '0;
		shadow_blocking = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_entries();
		test_directed_policy();
		test_blocking_fetch();
		test_random_traffic(350, 1'b0, 0, 0);
		test_random_traffic(350, 1'b1, 52, 0);
		test_random_traffic(350, 1'b0, 0, 52);
		test_random_traffic(350, 1'b1, 14, 14);

		drain_results();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ sim.f @@
sv/nfsr_pkg.sv
sv/nfsr_in_stage.sv
sv/nfsr_set_core.sv
sv/nfsr_out_stage.sv
sv/nmru_fifo_set_replacement_top.sv
tb/tb_nmru_fifo_set_replacement_top.sv
